// ===== design/lpfp_pkg.sv =====
package lpfp_pkg;

   localparam logic [23:0] BUG_DISTANCE = 24'h010101;
   localparam logic [15:0] BUG_REFLECT  = 16'h0101;
   localparam logic [23:0] LIMIT_RESET  = 24'(200 * 1000 / 2);
   localparam logic [7:0]  BYTE_MASK    = 8'hff;

   localparam int HEADER_BYTES  = 4;
   localparam int UNIT_BYTES    = 5;
   localparam int TRAILER_BYTES = 8;

   localparam logic KIND_UNIT    = 1'b0;
   localparam logic KIND_TRAILER = 1'b1;

   typedef struct packed {
      logic        result_kind;
      logic [2:0]  block_index;
      logic [5:0]  unit_index;
      logic [15:0] start_marker;
      logic [15:0] azimuth;
      logic [23:0] distance;
      logic [15:0] reflectivity;
      logic [15:0] motor_speed;
      logic [31:0] timestamp;
      logic [15:0] factory_word;
      logic        length_ok;
   } result_type;

endpackage

// ===== design/lidar_packet_field_parser.sv =====
// Lidar packet field parser.
// Input channel (req_): one packet byte per transfer, with req_last_byte set on
// the closing byte. Output channel (rsp_): one record per completed laser unit
// (result kind 0) and one trailer record on the closing byte (result kind 1).
// Unit records go out before the packet length is known; drop them when the
// trailer reports length_ok 0.
// Configuration: csr_write loads csr_wdata into the distance limit; write it
// only while no packet is in flight.
// Throughput: one byte per cycle, sustained while req_stall is low. Each byte
// is parsed by a single pass of logic into the output register of the skid
// stage; a record that meets a stalled output waits in the skid entry first.
// Stall: the result register is backed by one skid entry. req_stall rises
// only when that entry is occupied, i.e. after rsp_stall has held a full
// output register while another record arrived; it drops as soon as the
// output drains.
// Reset: synchronous; clears the packet position and counters, empties the
// output stage and loads the distance limit with 100000 (200 m in 2 mm units).
module lidar_packet_field_parser #(
   parameter int BLOCKS         = 6,
   parameter int UNITS          = 40,
   parameter int RESERVED_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [2:0]  rsp_block_index,
   output logic [5:0]  rsp_unit_index,
   output logic [15:0] rsp_start_marker,
   output logic [15:0] rsp_azimuth,
   output logic [23:0] rsp_distance,
   output logic [15:0] rsp_reflectivity,
   output logic [15:0] rsp_motor_speed,
   output logic [31:0] rsp_timestamp,
   output logic [15:0] rsp_factory_word,
   output logic        rsp_length_ok,
   input  logic        csr_write,
   input  logic [23:0] csr_wdata
);
   import lpfp_pkg::*;

   logic [23:0] limit_ff;
   logic        accept;
   logic        res_valid;
   logic        full;
   result_type  res;
   result_type  out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_wdata;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   lpfp_core #(
      .BLOCKS         (BLOCKS),
      .UNITS          (UNITS),
      .RESERVED_BYTES (RESERVED_BYTES)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .last_byte      (req_last_byte),
      .distance_limit (limit_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   lpfp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_result_kind  = out_data.result_kind;
   assign rsp_block_index  = out_data.block_index;
   assign rsp_unit_index   = out_data.unit_index;
   assign rsp_start_marker = out_data.start_marker;
   assign rsp_azimuth      = out_data.azimuth;
   assign rsp_distance     = out_data.distance;
   assign rsp_reflectivity = out_data.reflectivity;
   assign rsp_motor_speed  = out_data.motor_speed;
   assign rsp_timestamp    = out_data.timestamp;
   assign rsp_factory_word = out_data.factory_word;
   assign rsp_length_ok    = out_data.length_ok;

endmodule

// ===== design/lpfp_core.sv =====
module lpfp_core #(
   parameter int BLOCKS         = 6,
   parameter int UNITS          = 40,
   parameter int RESERVED_BYTES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   input  logic [23:0]         distance_limit,
   output logic                res_valid,
   output lpfp_pkg::result_type res
);
   import lpfp_pkg::*;

   localparam int BLOCK_SIZE    = HEADER_BYTES + UNIT_BYTES * UNITS;
   localparam int BLOCK_AREA    = BLOCKS * BLOCK_SIZE;
   localparam int TRAILER_START = BLOCK_AREA + RESERVED_BYTES;
   localparam int PKT_SIZE      = TRAILER_START + TRAILER_BYTES;
   localparam int PW            = $clog2(PKT_SIZE + 1);
   localparam int BW            = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

   logic [PW-1:0] pos_ff, pos_in;
   logic          ovl_ff, ovl_in;
   logic [BW-1:0] block_ff, block_in;
   logic          in_units_ff, in_units_in;
   logic [1:0]    hdr_ff, hdr_in;
   logic [5:0]    unit_ff, unit_in;
   logic [2:0]    ubyte_ff, ubyte_in;
   logic [15:0]   marker_ff, marker_in;
   logic [15:0]   az_ff, az_in;
   logic [31:0]   uasm_ff, uasm_in;
   logic [63:0]   trl_ff, trl_in;

   logic          live, in_area, in_trl, unit_done, filtered;
   logic [PW-1:0] trl_off;
   logic [23:0]   unit_dist;
   logic [15:0]   refl;
   logic [BW+2:0] block_ext;

   assign live    = pos_ff < PW'(PKT_SIZE);
   assign in_area = pos_ff < PW'(BLOCK_AREA);
   assign in_trl  = pos_ff >= PW'(TRAILER_START);
   assign trl_off = pos_ff - PW'(TRAILER_START);

   assign unit_dist = uasm_ff[23:0];
   assign refl      = {data_byte & BYTE_MASK, uasm_ff[31:24]};
   assign filtered  = (unit_dist == BUG_DISTANCE && refl == BUG_REFLECT) ||
                      unit_dist > distance_limit;
   assign block_ext = {3'b000, block_ff};

   always_comb begin
      pos_in      = pos_ff;
      ovl_in      = ovl_ff;
      block_in    = block_ff;
      in_units_in = in_units_ff;
      hdr_in      = hdr_ff;
      unit_in     = unit_ff;
      ubyte_in    = ubyte_ff;
      marker_in   = marker_ff;
      az_in       = az_ff;
      uasm_in     = uasm_ff;
      trl_in      = trl_ff;
      unit_done   = 1'b0;

      if (accept) begin
         if (live) begin
            pos_in = pos_ff + PW'(1);
            if (in_area) begin
               if (!in_units_ff) begin
                  case (hdr_ff)
                     2'd0:    marker_in = {8'h00, data_byte};
                     2'd1:    marker_in = {data_byte, marker_ff[7:0]};
                     2'd2:    az_in     = {8'h00, data_byte};
                     default: az_in     = {data_byte, az_ff[7:0]};
                  endcase
                  if (hdr_ff == 2'd3) begin
                     hdr_in      = 2'd0;
                     in_units_in = 1'b1;
                     unit_in     = 6'd0;
                     ubyte_in    = 3'd0;
                  end else begin
                     hdr_in = hdr_ff + 2'd1;
                  end
               end else begin
                  case (ubyte_ff)
                     3'd0:    uasm_in = {24'h000000, data_byte};
                     3'd1:    uasm_in[15:8]  = data_byte;
                     3'd2:    uasm_in[23:16] = data_byte;
                     3'd3:    uasm_in[31:24] = data_byte;
                     default: unit_done = 1'b1;
                  endcase
                  if (ubyte_ff == 3'd4) begin
                     ubyte_in = 3'd0;
                     if (unit_ff == 6'(UNITS - 1)) begin
                        unit_in     = 6'd0;
                        in_units_in = 1'b0;
                        block_in    = block_ff + BW'(1);
                     end else begin
                        unit_in = unit_ff + 6'd1;
                     end
                  end else begin
                     ubyte_in = ubyte_ff + 3'd1;
                  end
               end
            end else if (in_trl) begin
               for (int k = 0; k < TRAILER_BYTES; k++) begin
                  if (trl_off[2:0] == 3'(k)) trl_in[8*k +: 8] = data_byte;
               end
            end
         end else begin
            ovl_in = 1'b1;
         end
      end

      res       = '0;
      res_valid = 1'b0;
      if (accept && last_byte) begin
         res_valid        = 1'b1;
         res.result_kind  = KIND_TRAILER;
         res.motor_speed  = trl_in[15:0];
         res.timestamp    = trl_in[47:16];
         res.factory_word = trl_in[63:48];
         res.length_ok    = (pos_in == PW'(PKT_SIZE)) && !ovl_in;
      end else if (unit_done) begin
         res_valid        = 1'b1;
         res.result_kind  = KIND_UNIT;
         res.block_index  = block_ext[2:0];
         res.unit_index   = unit_ff;
         res.start_marker = marker_ff;
         res.azimuth      = az_ff;
         res.distance     = filtered ? 24'h000000 : unit_dist;
         res.reflectivity = filtered ? 16'h0000 : refl;
      end

      // drop all packet state after the closing byte
      if (accept && last_byte) begin
         pos_in      = '0;
         ovl_in      = 1'b0;
         block_in    = '0;
         in_units_in = 1'b0;
         hdr_in      = 2'd0;
         unit_in     = 6'd0;
         ubyte_in    = 3'd0;
         marker_in   = 16'h0000;
         az_in       = 16'h0000;
         uasm_in     = 32'h00000000;
         trl_in      = 64'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         ovl_ff      <= 1'b0;
         block_ff    <= '0;
         in_units_ff <= 1'b0;
         hdr_ff      <= 2'd0;
         unit_ff     <= 6'd0;
         ubyte_ff    <= 3'd0;
         marker_ff   <= 16'h0000;
         az_ff       <= 16'h0000;
         uasm_ff     <= 32'h00000000;
         trl_ff      <= 64'h0;
      end else begin
         pos_ff      <= pos_in;
         ovl_ff      <= ovl_in;
         block_ff    <= block_in;
         in_units_ff <= in_units_in;
         hdr_ff      <= hdr_in;
         unit_ff     <= unit_in;
         ubyte_ff    <= ubyte_in;
         marker_ff   <= marker_in;
         az_ff       <= az_in;
         uasm_ff     <= uasm_in;
         trl_ff      <= trl_in;
      end
   end

endmodule

// ===== design/lpfp_skid.sv =====
module lpfp_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  lpfp_pkg::result_type in_data,
   output logic                full,
   output logic                out_valid,
   output lpfp_pkg::result_type out_data,
   input  logic                out_stall
);
   import lpfp_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       drain;

   assign drain = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = in_data;
            out_valid_in = in_valid;
         end
      end else if (in_valid) begin
         // hold the new result while the output register is stalled
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// ===== tb/sv/lidar_record_checker.sv =====
`timescale 1ns / 1ps

module lidar_record_checker #(
   parameter int BLOCKS         = 6,
   parameter int UNITS          = 40,
   parameter int RESERVED_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_result_kind,
   input  logic [2:0]  rsp_block_index,
   input  logic [5:0]  rsp_unit_index,
   input  logic [15:0] rsp_start_marker,
   input  logic [15:0] rsp_azimuth,
   input  logic [23:0] rsp_distance,
   input  logic [15:0] rsp_reflectivity,
   input  logic [15:0] rsp_motor_speed,
   input  logic [31:0] rsp_timestamp,
   input  logic [15:0] rsp_factory_word,
   input  logic        rsp_length_ok,
   input  logic        csr_write,
   input  logic [23:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   localparam int BLOCK_SIZE    = lpfp_pkg::HEADER_BYTES + lpfp_pkg::UNIT_BYTES * UNITS;
   localparam int BLOCK_AREA    = BLOCKS * BLOCK_SIZE;
   localparam int TRAILER_START = BLOCK_AREA + RESERVED_BYTES;
   localparam int PKT_SIZE      = TRAILER_START + lpfp_pkg::TRAILER_BYTES;

   lpfp_pkg::result_type record_q[$];

   logic [23:0] dist_limit;
   int unsigned pkt_pos;
   logic        pkt_overlong;
   logic [15:0] blk_marker;
   logic [15:0] blk_azimuth;
   logic [39:0] unit_bytes;
   logic [63:0] trail_bytes;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic clear_packet();
      pkt_pos      = 0;
      pkt_overlong = 1'b0;
      blk_marker   = '0;
      blk_azimuth  = '0;
      unit_bytes   = '0;
      trail_bytes  = '0;
   endtask

   task automatic parse_byte(input logic [7:0] d, input logic last);
      lpfp_pkg::result_type rec;
      logic        unit_done;
      int unsigned off, blk, unit, ub;
      logic [23:0] unit_dist;
      logic [15:0] refl;
      rec       = '0;
      unit_done = 1'b0;
      blk       = 0;
      unit      = 0;
      unit_dist = '0;
      refl      = '0;
      if (pkt_pos < PKT_SIZE) begin
         if (pkt_pos < BLOCK_AREA) begin
            off = pkt_pos % BLOCK_SIZE;
            blk = pkt_pos / BLOCK_SIZE;
            if (off < lpfp_pkg::HEADER_BYTES) begin
               case (off)
                  0: blk_marker = {8'h00, d};
                  1: blk_marker[15:8] = d;
                  2: blk_azimuth = {8'h00, d};
                  default: blk_azimuth[15:8] = d;
               endcase
            end else begin
               unit = (off - lpfp_pkg::HEADER_BYTES) / lpfp_pkg::UNIT_BYTES;
               ub   = (off - lpfp_pkg::HEADER_BYTES) % lpfp_pkg::UNIT_BYTES;
               if (ub == 0) unit_bytes = '0;
               unit_bytes[8*ub +: 8] = d;
               if (ub == lpfp_pkg::UNIT_BYTES - 1) begin
                  unit_dist = unit_bytes[23:0];
                  refl      = unit_bytes[39:24];
                  // zero the known bug pattern and anything beyond range
                  if ((unit_dist == lpfp_pkg::BUG_DISTANCE && refl == lpfp_pkg::BUG_REFLECT) ||
                      unit_dist > dist_limit) begin
                     unit_dist = '0;
                     refl      = '0;
                  end
                  unit_done = 1'b1;
               end
            end
         end else if (pkt_pos >= TRAILER_START) begin
            trail_bytes[8*((pkt_pos - TRAILER_START) & 7) +: 8] = d;
         end
         pkt_pos++;
      end else begin
         pkt_overlong = 1'b1;
      end

      if (last) begin
         rec.result_kind  = lpfp_pkg::KIND_TRAILER;
         rec.motor_speed  = trail_bytes[15:0];
         rec.timestamp    = trail_bytes[47:16];
         rec.factory_word = trail_bytes[63:48];
         rec.length_ok    = (pkt_pos == PKT_SIZE) && !pkt_overlong;
         record_q = {record_q, rec};
         clear_packet();
      end else if (unit_done) begin
         rec.result_kind  = lpfp_pkg::KIND_UNIT;
         rec.block_index  = blk[2:0];
         rec.unit_index   = unit[5:0];
         rec.start_marker = blk_marker;
         rec.azimuth      = blk_azimuth;
         rec.distance     = unit_dist;
         rec.reflectivity = refl;
         record_q = {record_q, rec};
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      lpfp_pkg::result_type want;
      if (reset) begin
         dist_limit = lpfp_pkg::LIMIT_RESET;
         clear_packet();
         record_q.delete();
      end else begin
         if (csr_write) dist_limit = csr_wdata;
         if (req_valid && !req_stall) parse_byte(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            if (record_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: record transfer with none outstanding", $time);
            end else begin
               want = record_q.pop_front();
               check_field("result_kind", want.result_kind, rsp_result_kind);
               check_field("block_index", want.block_index, rsp_block_index);
               check_field("unit_index", want.unit_index, rsp_unit_index);
               check_field("start_marker", want.start_marker, rsp_start_marker);
               check_field("azimuth", want.azimuth, rsp_azimuth);
               check_field("distance", want.distance, rsp_distance);
               check_field("reflectivity", want.reflectivity, rsp_reflectivity);
               check_field("motor_speed", want.motor_speed, rsp_motor_speed);
               check_field("timestamp", want.timestamp, rsp_timestamp);
               check_field("factory_word", want.factory_word, rsp_factory_word);
               check_field("length_ok", want.length_ok, rsp_length_ok);
            end
         end
      end
      pending <= record_q.size();
   end

endmodule

// ===== tb/sv/tb_lidar_packet_field_parser.sv =====
`timescale 1ns / 1ps

module tb_lidar_packet_field_parser;

   localparam int BLOCKS         = 6;
   localparam int UNITS          = 40;
   localparam int RESERVED_BYTES = 8;
   localparam int BLOCK_SIZE     = lpfp_pkg::HEADER_BYTES + lpfp_pkg::UNIT_BYTES * UNITS;
   localparam int BLOCK_AREA     = BLOCKS * BLOCK_SIZE;
   localparam int PKT_SIZE       = BLOCK_AREA + RESERVED_BYTES + lpfp_pkg::TRAILER_BYTES;
   localparam int QUIET_LIMIT    = 5000;
   localparam int HOLD_CYCLES    = 300;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic        rsp_result_kind;
   logic [2:0]  rsp_block_index;
   logic [5:0]  rsp_unit_index;
   logic [15:0] rsp_start_marker;
   logic [15:0] rsp_azimuth;
   logic [23:0] rsp_distance;
   logic [15:0] rsp_reflectivity;
   logic [15:0] rsp_motor_speed;
   logic [31:0] rsp_timestamp;
   logic [15:0] rsp_factory_word;
   logic        rsp_length_ok;
   logic        csr_write     = 1'b0;
   logic [23:0] csr_wdata     = '0;

   int fail_count;
   int pending;

   int          idle_pct     = 0;
   int          stall_pct    = 0;
   bit          hold_trigger = 1'b0;
   logic [23:0] cur_limit    = lpfp_pkg::LIMIT_RESET;
   logic [7:0]  pkt_image [PKT_SIZE];

   lidar_packet_field_parser #(
      .BLOCKS(BLOCKS),
      .UNITS(UNITS),
      .RESERVED_BYTES(RESERVED_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_block_index(rsp_block_index),
      .rsp_unit_index(rsp_unit_index),
      .rsp_start_marker(rsp_start_marker),
      .rsp_azimuth(rsp_azimuth),
      .rsp_distance(rsp_distance),
      .rsp_reflectivity(rsp_reflectivity),
      .rsp_motor_speed(rsp_motor_speed),
      .rsp_timestamp(rsp_timestamp),
      .rsp_factory_word(rsp_factory_word),
      .rsp_length_ok(rsp_length_ok),
      .csr_write(csr_write),
      .csr_wdata(csr_wdata)
   );

   lidar_record_checker #(
      .BLOCKS(BLOCKS),
      .UNITS(UNITS),
      .RESERVED_BYTES(RESERVED_BYTES)
   ) records (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_block_index(rsp_block_index),
      .rsp_unit_index(rsp_unit_index),
      .rsp_start_marker(rsp_start_marker),
      .rsp_azimuth(rsp_azimuth),
      .rsp_distance(rsp_distance),
      .rsp_reflectivity(rsp_reflectivity),
      .rsp_motor_speed(rsp_motor_speed),
      .rsp_timestamp(rsp_timestamp),
      .rsp_factory_word(rsp_factory_word),
      .rsp_length_ok(rsp_length_ok),
      .csr_write(csr_write),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one byte transfer; enter and leave at a falling edge
   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // fill a whole packet with plausible blocks, units near the filter edges
   task automatic build_packet_image();
      int          base;
      logic [39:0] uw;
      for (int b = 0; b < BLOCKS; b++) begin
         base = b * BLOCK_SIZE;
         for (int k = 0; k < lpfp_pkg::HEADER_BYTES; k++) pkt_image[base + k] = 8'($urandom);
         for (int u = 0; u < UNITS; u++) begin
            case ($urandom_range(7))
               0: uw = {lpfp_pkg::BUG_REFLECT, lpfp_pkg::BUG_DISTANCE};
               1: uw = {16'($urandom), cur_limit};
               2: uw = {16'($urandom), cur_limit + 24'd1};
               3: uw = {16'hffff, 24'hffffff};
               4: uw = {lpfp_pkg::BUG_REFLECT, lpfp_pkg::BUG_DISTANCE ^ 24'h000001};
               5: uw = {16'($urandom), 24'($urandom_range(cur_limit))};
               default: uw = 40'({$urandom, $urandom});
            endcase
            for (int k = 0; k < lpfp_pkg::UNIT_BYTES; k++)
               pkt_image[base + lpfp_pkg::HEADER_BYTES + u * lpfp_pkg::UNIT_BYTES + k] =
                  uw[8*k +: 8];
         end
      end
      for (int i = BLOCK_AREA; i < PKT_SIZE; i++) pkt_image[i] = 8'($urandom);
   endtask

   task automatic send_packet(input int len, input bit noise);
      for (int i = 0; i < len; i++)
         send_byte((noise || i >= PKT_SIZE) ? 8'($urandom) : pkt_image[i], i == len - 1);
   endtask

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_trigger) begin
            hold_trigger = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int          budget;
      int          len;
      logic [39:0] uw;
      logic [23:0] lim;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single closing byte: empty trailer, length bad
      send_byte(8'hff, 1'b1);
      // header, bug unit, unit at the limit, unit past it closing the packet
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h12, 1'b0);
      repeat (5) send_byte(8'h01, 1'b0);
      uw = {16'hffff, lpfp_pkg::LIMIT_RESET};
      for (int k = 0; k < lpfp_pkg::UNIT_BYTES; k++) send_byte(uw[8*k +: 8], 1'b0);
      uw = {16'h8001, lpfp_pkg::LIMIT_RESET + 24'd1};
      for (int k = 0; k < lpfp_pkg::UNIT_BYTES; k++)
         send_byte(uw[8*k +: 8], k == lpfp_pkg::UNIT_BYTES - 1);

      for (int phase = 0; phase < 4; phase++) begin
         req_valid <= 1'b0;
         while (pending != 0) @(negedge clock);
         repeat (6) @(negedge clock);
         case (phase)
            0: lim = 24'hffffff;
            1: lim = 24'h000000;
            2: lim = lpfp_pkg::LIMIT_RESET;
            default: lim = 24'($urandom);
         endcase
         csr_write <= 1'b1;
         csr_wdata <= lim;
         cur_limit = lim;
         @(negedge clock);
         csr_write <= 1'b0;
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase

         if (phase == 2) begin
            // hold the output stalled at the start of one complete packet
            build_packet_image();
            hold_trigger = 1'b1;
            send_packet(PKT_SIZE, 1'b0);
         end

         // short and broken packets
         budget = 80;
         while (budget > 0) begin
            build_packet_image();
            if ($urandom_range(9) == 0) len = $urandom_range(1, 2 * BLOCK_SIZE);
            else len = $urandom_range(1, 50);
            send_packet(len, $urandom_range(9) == 0);
            budget -= len;
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
